// ===== hw/rtl/lsbc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsbc_pkg
// Shared types, constants and the generator step for the LCG s-box byte
// cipher.
// ----------------------------------------------------------------------------
package lsbc_pkg;

  localparam int unsigned TableEntries = 256;
  localparam int unsigned IdxW         = $clog2(TableEntries);
  localparam int unsigned ByteW        = 8;
  localparam int unsigned GenW         = 32;
  localparam int unsigned MultW        = 5;
  localparam int unsigned SwapCntW     = MultW + IdxW;
  localparam int unsigned CmdW         = 2;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 32;

  localparam logic [GenW-1:0]  LcgMult          = 32'h0808_8405;
  localparam logic [GenW-1:0]  StreamSeedRst    = 32'd20031955;
  localparam logic [GenW-1:0]  ShuffleSeedRst   = 32'd20091958;
  localparam logic [MultW-1:0] ShuffleMultRst   = 5'd8;

  // commands carried on the input word
  localparam logic [CmdW-1:0] CmdBuild   = 2'd0;
  localparam logic [CmdW-1:0] CmdEncrypt = 2'd1;
  localparam logic [CmdW-1:0] CmdDecrypt = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgStreamSeed  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgShuffleSeed = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgShuffleMult = 2'd2;

  typedef enum logic [1:0] {
    RdNone,
    RdData,
    RdSwap,
    RdInv
  } rd_e;

  typedef enum logic [2:0] {
    WrNone,
    WrFill,
    WrSwapA,
    WrSwapB,
    WrInv
  } wr_e;

  typedef struct packed {
    logic            accept;
    logic            g_seed;
    logic            g_step;
    logic            a_load;
    logic            b_load;
    rd_e             rd;
    wr_e             wr;
    logic [IdxW-1:0] idx;
    logic            out_load;
  } lsbc_cmd_t;

  typedef struct packed {
    logic             draw_hit;
    logic [MultW-1:0] mult;
  } lsbc_sts_t;

  function automatic logic [GenW-1:0] lcg_next(input logic [GenW-1:0] s);
    return s * LcgMult + 32'd1;
  endfunction

endpackage

// ===== hw/rtl/lsbc_if.sv =====
// ----------------------------------------------------------------------------
// lsbc_in_if / lsbc_out_if
// Valid/ready channels for the cipher's input and result words.
// ----------------------------------------------------------------------------
interface lsbc_in_if import lsbc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CmdW-1:0]     cmd;
  logic [ByteW-1:0]    in_byte;
  logic                first_of_message;

  modport source (output valid, cmd, in_byte, first_of_message, input ready);
  modport sink   (input valid, cmd, in_byte, first_of_message, output ready);
endinterface

interface lsbc_out_if import lsbc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             build_done;

  modport source (output valid, out_byte, build_done, input ready);
  modport sink   (input valid, out_byte, build_done, output ready);
endinterface

// ===== hw/rtl/lsbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsbc_ctrl
// Sequencer: handshakes, table build steps and result hand-off.
// ----------------------------------------------------------------------------
module lsbc_ctrl import lsbc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [CmdW-1:0] in_cmd_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output lsbc_cmd_t       cmd_o,
  input  lsbc_sts_t       sts_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_FILL,
    S_DRAW_A,
    S_DRAW_B,
    S_SW_RD,
    S_SW_WA,
    S_SW_WB,
    S_INV_RD,
    S_INV_WR
  } state_e;

  state_e              state_q;
  logic [IdxW-1:0]     idx_q;
  logic [SwapCntW-1:0] swp_q;
  logic                out_valid_q;
  logic                pend_q;

  logic out_free;
  logic flush;
  logic acc;
  logic idx_last;

  assign out_free   = !out_valid_q || out_ready_i;
  assign flush      = pend_q && out_free;
  assign in_ready_o = (state_q == S_IDLE) && (!pend_q || out_free);
  assign acc        = in_valid_i && in_ready_o;
  assign idx_last   = (idx_q == IdxW'(TableEntries - 1));
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.rd       = RdNone;
    cmd_o.wr       = WrNone;
    cmd_o.idx      = idx_q;
    cmd_o.accept   = acc;
    cmd_o.out_load = flush;
    case (state_q)
      S_IDLE: begin
        cmd_o.g_seed = acc && (in_cmd_i == CmdBuild);
      end
      S_READ:   cmd_o.rd = RdData;
      S_FILL:   cmd_o.wr = WrFill;
      S_DRAW_A: begin
        cmd_o.g_step = 1'b1;
        cmd_o.a_load = 1'b1;
      end
      S_DRAW_B: begin
        cmd_o.g_step = 1'b1;
        cmd_o.b_load = 1'b1;
      end
      S_SW_RD:  cmd_o.rd = RdSwap;
      S_SW_WA:  cmd_o.wr = WrSwapA;
      S_SW_WB:  cmd_o.wr = WrSwapB;
      S_INV_RD: cmd_o.rd = RdInv;
      S_INV_WR: cmd_o.wr = WrInv;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      swp_q       <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      if (flush) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            if (in_cmd_i == CmdBuild) begin
              state_q <= S_FILL;
              idx_q   <= '0;
              swp_q   <= {sts_i.mult, IdxW'(0)};
            end else begin
              state_q <= S_READ;
            end
          end
        end
        S_READ: begin
          pend_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        S_FILL: begin
          idx_q <= idx_q + IdxW'(1);
          if (idx_last) begin
            state_q <= (swp_q == '0) ? S_INV_RD : S_DRAW_A;
          end
        end
        S_DRAW_A: state_q <= S_DRAW_B;
        S_DRAW_B: begin
          if (!sts_i.draw_hit) begin
            state_q <= S_SW_RD;
          end
        end
        S_SW_RD: state_q <= S_SW_WA;
        S_SW_WA: state_q <= S_SW_WB;
        S_SW_WB: begin
          swp_q   <= swp_q - SwapCntW'(1);
          state_q <= (swp_q == SwapCntW'(1)) ? S_INV_RD : S_DRAW_A;
        end
        S_INV_RD: state_q <= S_INV_WR;
        S_INV_WR: begin
          idx_q <= idx_q + IdxW'(1);
          if (idx_last) begin
            pend_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_INV_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/lsbc_dp.sv =====
// ----------------------------------------------------------------------------
// lsbc_dp
// Datapath: config registers, generators, substitution tables, result word.
// ----------------------------------------------------------------------------
module lsbc_dp import lsbc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic [CmdW-1:0]    in_cmd_i,
  input  logic [ByteW-1:0]   in_byte_i,
  input  logic               in_first_i,
  input  lsbc_cmd_t          cmd_i,
  output lsbc_sts_t          sts_o,
  output logic [ByteW-1:0]   out_byte_o,
  output logic               out_build_o
);

  logic [GenW-1:0]  stream_seed_q;
  logic [GenW-1:0]  shuffle_seed_q;
  logic [MultW-1:0] shuffle_mult_q;
  logic [GenW-1:0]  ks_q;
  logic [GenW-1:0]  g_q;
  logic [IdxW-1:0]  a_q;
  logic [IdxW-1:0]  b_q;
  logic [CmdW-1:0]  cmd_q;
  logic [ByteW-1:0] byte_q;
  logic [ByteW-1:0] rd_a_q;
  logic [ByteW-1:0] rd_b_q;
  logic [ByteW-1:0] rd_inv_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_build_q;

  logic [ByteW-1:0] fwd_mem [TableEntries];
  logic [ByteW-1:0] inv_mem [TableEntries];

  logic [GenW-1:0]  g_nxt;
  logic [IdxW-1:0]  draw;
  logic [GenW-1:0]  ks_base;
  logic             is_data;
  logic [IdxW-1:0]  rd_addr_a;
  logic [IdxW-1:0]  rd_addr_inv;
  logic             fwd_we;
  logic [IdxW-1:0]  fwd_waddr;
  logic [ByteW-1:0] fwd_wdata;
  logic [ByteW-1:0] out_byte_d;

  assign g_nxt   = lcg_next(g_q);
  assign draw    = g_nxt[GenW-1 -: IdxW];
  assign ks_base = in_first_i ? stream_seed_q : ks_q;
  assign is_data = (in_cmd_i == CmdEncrypt) || (in_cmd_i == CmdDecrypt);

  assign sts_o.draw_hit = (draw == a_q);
  assign sts_o.mult     = shuffle_mult_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_seed_q  <= StreamSeedRst;
      shuffle_seed_q <= ShuffleSeedRst;
      shuffle_mult_q <= ShuffleMultRst;
      ks_q           <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgStreamSeed:  stream_seed_q  <= cfg_wdata_i[GenW-1:0];
          CfgShuffleSeed: shuffle_seed_q <= cfg_wdata_i[GenW-1:0];
          CfgShuffleMult: shuffle_mult_q <= cfg_wdata_i[MultW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.accept && is_data) begin
        ks_q <= lcg_next(ks_base);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q  <= in_cmd_i;
      byte_q <= in_byte_i;
    end
    if (cmd_i.g_seed) begin
      g_q <= shuffle_seed_q;
    end else if (cmd_i.g_step) begin
      g_q <= g_nxt;
    end
    if (cmd_i.a_load) a_q <= draw;
    if (cmd_i.b_load) b_q <= draw;
  end

  always_comb begin
    case (cmd_i.rd)
      RdSwap:  rd_addr_a = a_q;
      RdInv:   rd_addr_a = cmd_i.idx;
      default: rd_addr_a = byte_q;
    endcase
  end
  assign rd_addr_inv = byte_q ^ ks_q[GenW-1 -: IdxW];

  always_comb begin
    fwd_we    = 1'b1;
    fwd_waddr = cmd_i.idx;
    fwd_wdata = cmd_i.idx;
    case (cmd_i.wr)
      WrFill: ;
      WrSwapA: begin
        fwd_waddr = a_q;
        fwd_wdata = rd_b_q;
      end
      WrSwapB: begin
        fwd_waddr = b_q;
        fwd_wdata = rd_a_q;
      end
      default: fwd_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fwd_we) begin
      fwd_mem[fwd_waddr] <= fwd_wdata;
    end
    if (cmd_i.wr == WrInv) begin
      inv_mem[rd_a_q] <= cmd_i.idx;
    end
    if (cmd_i.rd != RdNone) begin
      rd_a_q   <= fwd_mem[rd_addr_a];
      rd_b_q   <= fwd_mem[b_q];
      rd_inv_q <= inv_mem[rd_addr_inv];
    end
  end

  always_comb begin
    case (cmd_q)
      CmdEncrypt: out_byte_d = rd_a_q ^ ks_q[GenW-1 -: ByteW];
      CmdDecrypt: out_byte_d = rd_inv_q;
      default:    out_byte_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_byte_q  <= out_byte_d;
      out_build_q <= (cmd_q == CmdBuild);
    end
  end

  assign out_byte_o  = out_byte_q;
  assign out_build_o = out_build_q;

endmodule

// ===== hw/rtl/lcg_sbox_byte_cipher.sv =====
// ----------------------------------------------------------------------------
// lcg_sbox_byte_cipher
// Byte substitution cipher keyed by a 32-bit LCG keystream.
// ----------------------------------------------------------------------------
// Encrypt/decrypt word: keystream step on acceptance, then table read;
//   result word loaded when the output is free; next word after the read.
// Build: fill, then mult x 256 swaps (a draw equal to the first redraws),
//   then inverse, on the single-write-port tables.
// Reset clears control and keystream and restores config defaults; tables
//   hold no reset value.
module lcg_sbox_byte_cipher import lsbc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  lsbc_in_if.sink             in_if,
  lsbc_out_if.source          out_if
);

  lsbc_cmd_t cmd;
  lsbc_sts_t sts;

  lsbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_cmd_i    (in_if.cmd),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lsbc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_cmd_i    (in_if.cmd),
    .in_byte_i   (in_if.in_byte),
    .in_first_i  (in_if.first_of_message),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_byte_o  (out_if.out_byte),
    .out_build_o (out_if.build_done)
  );

endmodule

// ===== hw/rtl/lsbc_checker.sv =====
// ----------------------------------------------------------------------------
// lsbc_checker
// Port-level checks for the cipher, bound to the top level.
// ----------------------------------------------------------------------------
module lsbc_checker import lsbc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [ByteW-1:0] out_byte_i,
  input logic             build_done_i
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_byte_i) && $stable(build_done_i))
    else $error("result word changed while stalled");

  a_build_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && build_done_i |-> out_byte_i == '0)
    else $error("build acknowledge with non-zero byte");

  // one word read at a time: no acceptance in the cycle after one
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready straight after acceptance");

endmodule

bind lcg_sbox_byte_cipher lsbc_checker u_lsbc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .out_byte_i   (out_if.out_byte),
  .build_done_i (out_if.build_done)
);

// ===== dv/tb_lcg_sbox_byte_cipher.sv =====
// ----------------------------------------------------------------------------
// tb_lcg_sbox_byte_cipher
// Self-checking bench for the LCG s-box byte cipher. Words from a pending
// queue are driven on the input channel and predicted on acceptance. The
// prediction keeps its own copies of the tables, the keystream generator and
// the registers. Result words are compared in order. Phases cover reset and
// extreme register settings, large shuffle multipliers, changing
// idle patterns and one long receiver stall.
// ----------------------------------------------------------------------------
module tb_lcg_sbox_byte_cipher;
  import lsbc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned StallLen   = 400;
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  typedef struct packed {
    logic [CmdW-1:0]  op;
    logic [ByteW-1:0] data;
    logic             restart;
  } cipher_word_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             build_done;
  } cipher_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  lsbc_in_if  in_if ();
  lsbc_out_if out_if ();

  lcg_sbox_byte_cipher u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_if),
    .out_if      (out_if)
  );

  always #1 clk_i = ~clk_i;

  // predicted block state
  logic [ByteW-1:0] fwd_sbox [TableEntries];
  logic [ByteW-1:0] inv_sbox [TableEntries];
  logic [GenW-1:0]  ks_gen = '0;
  logic [GenW-1:0]  stream_seed_m = StreamSeedRst;
  logic [GenW-1:0]  shuffle_seed_m = ShuffleSeedRst;
  logic [MultW-1:0] shuffle_mult_m = ShuffleMultRst;

  cipher_word_t   pend_q [$];
  cipher_result_t expect_q [$];
  int unsigned    n_queued = 0;
  int unsigned    n_accepted = 0;
  int unsigned    errors = 0;
  int unsigned    cycle_cnt = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;
  bit             in_taken = 1'b0;
  bit             stall_go = 1'b0;
  bit             stall_done = 1'b0;
  int unsigned    hold_left = 0;

  function automatic cipher_result_t cipher_predict(input cipher_word_t w);
    cipher_result_t   r;
    logic [GenW-1:0]  g;
    logic [ByteW-1:0] a, b, t;
    int unsigned      n_swaps;
    r = '0;
    case (w.op)
      CmdBuild: begin
        g = shuffle_seed_m;
        n_swaps = shuffle_mult_m * TableEntries;
        for (int i = 0; i < TableEntries; i++) fwd_sbox[i] = i[ByteW-1:0];
        for (int unsigned s = 0; s < n_swaps; s++) begin
          g = g * LcgMult + 32'd1;
          a = g[31:24];
          do begin
            g = g * LcgMult + 32'd1;
            b = g[31:24];
          end while (a == b);
          t = fwd_sbox[a];
          fwd_sbox[a] = fwd_sbox[b];
          fwd_sbox[b] = t;
        end
        for (int i = 0; i < TableEntries; i++) inv_sbox[fwd_sbox[i]] = i[ByteW-1:0];
        r.build_done = 1'b1;
      end
      CmdEncrypt, CmdDecrypt: begin
        if (w.restart) ks_gen = stream_seed_m;
        ks_gen = ks_gen * LcgMult + 32'd1;
        if (w.op == CmdEncrypt) r.out_byte = fwd_sbox[w.data] ^ ks_gen[31:24];
        else r.out_byte = inv_sbox[w.data ^ ks_gen[31:24]];
      end
      default: ;
    endcase
    return r;
  endfunction

  // sender
  always @(negedge clk_i) begin
    cipher_word_t nxt;
    if (!rst_ni) begin
      in_if.valid            <= 1'b0;
      in_if.cmd              <= CmdBuild;
      in_if.in_byte          <= '0;
      in_if.first_of_message <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pend_q.pop_front();
        in_if.valid            <= 1'b1;
        in_if.cmd              <= nxt.op;
        in_if.in_byte          <= nxt.data;
        in_if.first_of_message <= nxt.restart;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (stall_go && !stall_done) begin
        out_if.ready <= 1'b0;
        hold_left    <= StallLen;
        stall_done   <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin
    cipher_word_t   w;
    cipher_result_t got, exp;
    bit             bad;
    in_taken = 1'b0;
    if (rst_ni && in_if.valid && in_if.ready) begin
      in_taken = 1'b1;
      w = '{op: in_if.cmd, data: in_if.in_byte, restart: in_if.first_of_message};
      expect_q.push_back(cipher_predict(w));
      n_accepted++;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_byte: out_if.out_byte, build_done: out_if.build_done};
      exp = 'x;
      bad = (expect_q.size() == 0);
      if (!bad) begin
        exp = expect_q.pop_front();
        bad = (exp !== got);
      end
      if (bad) begin
        errors++;
        if (errors <= 10)
          $display({"result word mismatch at cycle %0d: exp out_byte %02h build_done %b,",
                    " got out_byte %02h build_done %b"},
                   cycle_cnt, exp.out_byte, exp.build_done, got.out_byte, got.build_done);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_word(input logic [CmdW-1:0] op, input logic [ByteW-1:0] data,
                            input logic restart);
    pend_q.push_back('{op: op, data: data, restart: restart});
    n_queued++;
  endtask

  task automatic wait_idle();
    while (n_accepted != n_queued || expect_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CfgStreamSeed:  stream_seed_m  = data;
      CfgShuffleSeed: shuffle_seed_m = data;
      CfgShuffleMult: shuffle_mult_m = data[MultW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly whole messages, some lone words, unused commands and rare rebuilds
  task automatic queue_traffic(input int unsigned n_words);
    int unsigned       cnt, len, r;
    logic [CmdW-1:0]   op;
    cnt = 0;
    while (cnt < n_words) begin
      r = $urandom_range(99);
      if (r < 80) begin
        len = $urandom_range(12, 1);
        op  = $urandom_range(1) ? CmdEncrypt : CmdDecrypt;
        for (int unsigned k = 0; k < len; k++) begin
          if ($urandom_range(4) == 0) op = (op == CmdEncrypt) ? CmdDecrypt : CmdEncrypt;
          queue_word(op, ByteW'($urandom_range(255)), k == 0);
        end
        cnt += len;
      end else if (r < 88) begin
        queue_word(CmdUnused, ByteW'($urandom_range(255)), 1'($urandom_range(1)));
      end else if (r < 98 || shuffle_mult_m > 8) begin
        queue_word($urandom_range(1) ? CmdEncrypt : CmdDecrypt, ByteW'($urandom_range(255)),
                   1'($urandom_range(1)));
        cnt++;
      end else begin
        queue_word(CmdBuild, ByteW'($urandom_range(255)), 1'($urandom_range(1)));
        cnt++;
      end
    end
  endtask

  task automatic run_phase(input logic [GenW-1:0] s_seed, input logic [GenW-1:0] t_seed,
                           input logic [MultW-1:0] mult, input int unsigned n_words);
    wait_idle();
    write_reg(CfgStreamSeed, s_seed);
    write_reg(CfgShuffleSeed, t_seed);
    write_reg(CfgShuffleMult, {{(CfgDataW-MultW){1'b0}}, mult});
    queue_word(CmdBuild, ByteW'($urandom_range(255)), 1'($urandom_range(1)));
    queue_traffic(n_words);
  endtask

  initial begin
    cfg_we_i               = 1'b0;
    cfg_idx_i              = CfgStreamSeed;
    cfg_wdata_i            = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 26;
    recv_idle_pct = 76;
    // reset register values; data straight after the first build runs on
    // the cleared keystream
    queue_word(CmdBuild,   8'hFF, 1'b1);
    queue_word(CmdEncrypt, 8'h00, 1'b0);
    queue_word(CmdEncrypt, 8'hFF, 1'b0);
    queue_word(CmdDecrypt, 8'h00, 1'b1);
    queue_word(CmdDecrypt, 8'hFF, 1'b0);
    queue_word(CmdUnused,  8'hA5, 1'b1);
    queue_word(CmdEncrypt, 8'h5A, 1'b0);
    queue_word(CmdEncrypt, 8'h80, 1'b1);
    queue_word(CmdDecrypt, 8'h7F, 1'b0);
    queue_word(CmdUnused,  8'h00, 1'b0);
    queue_word(CmdBuild,   8'h00, 1'b0);
    queue_word(CmdDecrypt, 8'h01, 1'b0);
    queue_word(CmdEncrypt, 8'hFE, 1'b1);

    run_phase(32'h0000_0000, 32'h0000_0000, 5'd1, 320);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 320);

    wait_idle();
    send_idle_pct = 76;
    recv_idle_pct = 26;
    run_phase($urandom, $urandom, 5'd16, 320);
    run_phase($urandom, $urandom, 5'd31, 300);

    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase($urandom, $urandom, 5'($urandom_range(8, 2)), 320);
    stall_go = 1'b1;
    run_phase($urandom, $urandom, 5'($urandom_range(24, 17)), 320);

    wait_idle();
    errors += expect_q.size();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
